/* rtl/bcpu_pkg.sv */
package bcpu_pkg;

  // machine sizes
  localparam int NUM_REGS    = 8;
  localparam int MEM_DEPTH   = 65536;
  localparam int NUM_PORTS   = 256;
  localparam int REG_AW      = $clog2(NUM_REGS);
  localparam int MEM_AW      = $clog2(MEM_DEPTH);
  localparam int PORT_AW     = $clog2(NUM_PORTS);

  // front to back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // stack pointer value after reset
  localparam logic [15:0] SP_RESET = 16'hFFFF;

  // command codes as they arrive on the input word
  typedef enum logic [3:0] {
    CMD_MW   = 4'd0,
    CMD_LW   = 4'd1,
    CMD_SW   = 4'd2,
    CMD_PUSH = 4'd3,
    CMD_POP  = 4'd4,
    CMD_LDA  = 4'd5,
    CMD_JNZ  = 4'd6,
    CMD_INB  = 4'd7,
    CMD_OUTB = 4'd8,
    CMD_ADD  = 4'd9,
    CMD_ADC  = 4'd10,
    CMD_AND  = 4'd11,
    CMD_OR   = 4'd12,
    CMD_NOR  = 4'd13,
    CMD_CMP  = 4'd14
  } cmd_t;

  // internal operation class, including a no-op for undefined codes
  typedef enum logic [3:0] {
    OP_NOP,
    OP_MOVI,
    OP_LOAD,
    OP_STORE,
    OP_PUSH,
    OP_POP,
    OP_LDHL,
    OP_JNZ,
    OP_IN,
    OP_OUT,
    OP_ADD,
    OP_ADC,
    OP_AND,
    OP_OR,
    OP_NOR,
    OP_CMP
  } op_t;

  // decoded instruction held in the queue
  typedef struct packed {
    op_t                op;
    logic               reg_wr;
    logic               mem_wr;
    logic [REG_AW-1:0]  rsel;
    logic [7:0]         imm;
    logic [15:0]        addr;
    logic [PORT_AW-1:0] psel;
  } qent_t;

endpackage

/* rtl/bcpu_ifs.sv */
// instruction channel
interface bcpu_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  command;
  logic [2:0]  reg_select;
  logic [7:0]  immediate;
  logic [15:0] mem_address;
  logic [7:0]  port_number;

  modport source (
    output valid, command, reg_select, immediate, mem_address, port_number,
    input  ready
  );
  modport sink (
    input  valid, command, reg_select, immediate, mem_address, port_number,
    output ready
  );
endinterface

// result channel
interface bcpu_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  reg_value;
  logic        carry_out;
  logic        equal_out;
  logic        less_out;
  logic        jump_taken;
  logic [7:0]  jump_target;
  logic [15:0] stack_ptr_out;
  logic [15:0] hl_out;
  logic [7:0]  port_value;

  modport source (
    output valid, reg_value, carry_out, equal_out, less_out, jump_taken,
           jump_target, stack_ptr_out, hl_out, port_value,
    input  ready
  );
  modport sink (
    input  valid, reg_value, carry_out, equal_out, less_out, jump_taken,
           jump_target, stack_ptr_out, hl_out, port_value,
    output ready
  );
endinterface

/* rtl/bcpu_front.sv */
module bcpu_front (
  bcpu_in_if.sink        instr,
  output logic           wr_valid,
  input  logic           wr_ready,
  output bcpu_pkg::qent_t wr_data
);
  import bcpu_pkg::*;

  // handshake passes straight to the queue
  assign wr_valid    = instr.valid;
  assign instr.ready = wr_ready;

  // classify the command and pick out the operand fields
  always_comb begin
    wr_data        = '0;
    wr_data.rsel   = instr.reg_select[REG_AW-1:0];
    wr_data.imm    = instr.immediate;
    wr_data.addr   = instr.mem_address;
    wr_data.psel   = instr.port_number[PORT_AW-1:0];
    wr_data.op     = OP_NOP;
    wr_data.reg_wr = 1'b0;
    wr_data.mem_wr = 1'b0;
    unique case (cmd_t'(instr.command))
      CMD_MW: begin
        wr_data.op     = OP_MOVI;
        wr_data.reg_wr = 1'b1;
      end
      CMD_LW: begin
        wr_data.op     = OP_LOAD;
        wr_data.reg_wr = 1'b1;
      end
      CMD_SW: begin
        wr_data.op     = OP_STORE;
        wr_data.mem_wr = 1'b1;
      end
      CMD_PUSH: begin
        wr_data.op     = OP_PUSH;
        wr_data.mem_wr = 1'b1;
      end
      CMD_POP: begin
        wr_data.op     = OP_POP;
        wr_data.reg_wr = 1'b1;
      end
      CMD_LDA:  wr_data.op = OP_LDHL;
      CMD_JNZ:  wr_data.op = OP_JNZ;
      CMD_INB: begin
        wr_data.op     = OP_IN;
        wr_data.reg_wr = 1'b1;
      end
      CMD_OUTB: wr_data.op = OP_OUT;
      CMD_ADD: begin
        wr_data.op     = OP_ADD;
        wr_data.reg_wr = 1'b1;
      end
      CMD_ADC: begin
        wr_data.op     = OP_ADC;
        wr_data.reg_wr = 1'b1;
      end
      CMD_AND: begin
        wr_data.op     = OP_AND;
        wr_data.reg_wr = 1'b1;
      end
      CMD_OR: begin
        wr_data.op     = OP_OR;
        wr_data.reg_wr = 1'b1;
      end
      CMD_NOR: begin
        wr_data.op     = OP_NOR;
        wr_data.reg_wr = 1'b1;
      end
      CMD_CMP:  wr_data.op = OP_CMP;
      default:  wr_data.op = OP_NOP;
    endcase
  end

endmodule

/* rtl/bcpu_queue.sv */
module bcpu_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  bcpu_pkg::qent_t wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output bcpu_pkg::qent_t rd_data
);
  import bcpu_pkg::*;

  qent_t               slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                push;
  logic                pop;

  assign wr_ready = (count != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/bcpu_back.sv */
module bcpu_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_ready,
  input  bcpu_pkg::qent_t q_data,
  bcpu_out_if.source      result
);
  import bcpu_pkg::*;

  // architectural state
  logic [7:0]         regs [NUM_REGS];
  logic [7:0]         mem [MEM_DEPTH];
  logic [7:0]         port_mem [NUM_PORTS];
  logic [NUM_PORTS-1:0] port_vld;
  logic [15:0]        sp;
  logic [15:0]        hl;
  logic               carry;
  logic               equal;
  logic               less;

  // execute stage
  logic               b_valid;
  qent_t              b_ent;
  logic [15:0]        b_sp;
  logic [15:0]        b_hl;
  logic [MEM_AW-1:0]  b_maddr;
  logic [7:0]         mem_rd;
  logic               mem_byp;
  logic [7:0]         mem_byp_data;
  logic [7:0]         port_rd;
  logic               port_byp;
  logic [7:0]         port_byp_data;

  // output register
  logic               out_valid;

  logic               launch;
  logic               b_fire;
  logic [15:0]        sp_next;
  logic [15:0]        hl_next;
  logic [MEM_AW-1:0]  raddr;
  logic               mem_we;
  logic [7:0]         mem_wdata;
  logic               port_we;
  logic [7:0]         rv;
  logic [7:0]         ld;
  logic [7:0]         pd;
  logic [7:0]         wval;
  logic [7:0]         diff;
  logic               cmp_lt;

  assign b_fire  = b_valid && (!out_valid || result.ready);
  assign launch  = q_valid && (!b_valid || b_fire);
  assign q_ready = launch;

  // stack pointer, hl and memory address resolve at launch
  always_comb begin
    sp_next = sp;
    hl_next = hl;
    raddr   = q_data.addr[MEM_AW-1:0];
    unique case (q_data.op)
      OP_PUSH: begin
        raddr   = sp[MEM_AW-1:0];
        sp_next = sp - 16'd1;
      end
      OP_POP: begin
        sp_next = sp + 16'd1;
        raddr   = sp_next[MEM_AW-1:0];
      end
      OP_LDHL: hl_next = q_data.addr;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp      <= SP_RESET;
      hl      <= '0;
      b_valid <= 1'b0;
    end else begin
      if (launch) begin
        sp <= sp_next;
        hl <= hl_next;
      end
      if (launch) begin
        b_valid <= 1'b1;
      end else if (b_fire) begin
        b_valid <= 1'b0;
      end
    end
  end

  // execute stage payload
  always_ff @(posedge clk) begin
    if (launch) begin
      b_ent   <= q_data;
      b_sp    <= sp_next;
      b_hl    <= hl_next;
      b_maddr <= raddr;
    end
  end

  // write side, driven by the retiring word
  assign mem_we    = b_fire && b_ent.mem_wr;
  assign mem_wdata = (b_ent.op == OP_PUSH) ? b_ent.imm : rv;
  assign port_we   = b_fire && (b_ent.op == OP_OUT);

  // data memory with registered read and same-cycle write bypass
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[b_maddr] <= mem_wdata;
    end
    if (launch) begin
      mem_rd       <= mem[raddr];
      mem_byp      <= mem_we && (b_maddr == raddr);
      mem_byp_data <= mem_wdata;
    end
  end

  // port latches; an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (port_we) begin
      port_mem[b_ent.psel] <= rv;
    end
    if (launch) begin
      port_rd       <= port_vld[q_data.psel] ? port_mem[q_data.psel] : 8'd0;
      port_byp      <= port_we && (b_ent.psel == q_data.psel);
      port_byp_data <= rv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      port_vld <= '0;
    end else if (port_we) begin
      port_vld[b_ent.psel] <= 1'b1;
    end
  end

  // operand selection and alu
  assign rv     = regs[b_ent.rsel];
  assign ld     = mem_byp ? mem_byp_data : mem_rd;
  assign pd     = port_byp ? port_byp_data : port_rd;
  assign diff   = rv - b_ent.imm;
  assign cmp_lt = (diff > rv);

  always_comb begin
    wval = rv;
    unique case (b_ent.op)
      OP_MOVI:         wval = b_ent.imm;
      OP_LOAD, OP_POP: wval = ld;
      OP_IN:           wval = pd;
      OP_ADD:          wval = rv + b_ent.imm;
      OP_ADC:          wval = rv + b_ent.imm + {7'd0, carry};
      OP_AND:          wval = rv & b_ent.imm;
      OP_OR:           wval = rv | b_ent.imm;
      OP_NOR:          wval = ~(rv | b_ent.imm);
      default:         wval = rv;
    endcase
  end

  // register file and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= '0;
      end
      carry <= 1'b0;
      equal <= 1'b0;
      less  <= 1'b0;
    end else if (b_fire) begin
      if (b_ent.reg_wr) begin
        regs[b_ent.rsel] <= wval;
      end
      if (b_ent.op == OP_CMP) begin
        carry <= (rv < b_ent.imm);
        equal <= (rv == b_ent.imm);
        less  <= cmp_lt;
      end
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      result.reg_value     <= b_ent.reg_wr ? wval : rv;
      result.carry_out     <= (b_ent.op == OP_CMP) ? (rv < b_ent.imm) : carry;
      result.equal_out     <= (b_ent.op == OP_CMP) ? (rv == b_ent.imm) : equal;
      result.less_out      <= (b_ent.op == OP_CMP) ? cmp_lt : less;
      result.jump_taken    <= (b_ent.op == OP_JNZ) && (regs[0] != 8'd0);
      result.jump_target   <= ((b_ent.op == OP_JNZ) && (regs[0] != 8'd0)) ?
                              b_ent.imm : 8'd0;
      result.stack_ptr_out <= b_sp;
      result.hl_out        <= b_hl;
      result.port_value    <= (b_ent.op == OP_OUT) ? rv : pd;
    end
  end

  assign result.valid = out_valid;

endmodule

/* rtl/byte_cpu_execute_unit.sv */
// path: an accepted word waits in the queue, passes the execute stage, and its result
// is valid once it is in the output register
// throughput: one instruction per cycle unless output stalls; the memory read is issued
// one stage ahead of execute, bypassed from the retiring word; dependencies never stall
// reset: registers, flags, hl and port latches clear to zero, stack pointer to 0xFFFF,
// data memory is not cleared and is ready at once
module byte_cpu_execute_unit (
  input  logic       clk,
  input  logic       rst,
  bcpu_in_if.sink    instr,
  bcpu_out_if.source result
);
  import bcpu_pkg::*;

  logic  wr_valid;
  logic  wr_ready;
  qent_t wr_data;
  logic  q_valid;
  logic  q_ready;
  qent_t q_data;

  // decode
  bcpu_front u_front (
    .instr    (instr),
    .wr_valid (wr_valid),
    .wr_ready (wr_ready),
    .wr_data  (wr_data)
  );

  // decoupling queue
  bcpu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (wr_valid),
    .wr_ready (wr_ready),
    .wr_data  (wr_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  // execute
  bcpu_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data),
    .result  (result)
  );

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import bcpu_pkg::*;

  // command 15 has no meaning and must leave the machine untouched
  localparam logic [3:0] CMD_UNDEF = 4'd15;
  // idle wait after the last result is back, before the next test
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [3:0]  command;
    logic [2:0]  reg_select;
    logic [7:0]  immediate;
    logic [15:0] mem_address;
    logic [7:0]  port_number;
  } instr_word_t;

  typedef struct packed {
    logic [7:0]  reg_value;
    logic        carry;
    logic        equal;
    logic        less;
    logic        jump_taken;
    logic [7:0]  jump_target;
    logic [15:0] stack_ptr;
    logic [15:0] hl;
    logic [7:0]  port_value;
  } exec_result_t;

  logic clk;
  logic rst;

  bcpu_in_if  instr_ch ();
  bcpu_out_if result_ch ();

  byte_cpu_execute_unit dut (
    .clk    (clk),
    .rst    (rst),
    .instr  (instr_ch),
    .result (result_ch)
  );

  // machine state as the block should hold it
  logic [7:0]  gpr [NUM_REGS];
  logic [7:0]  data_mem [int];
  int          written_addrs [$];
  logic [7:0]  port_latch [NUM_PORTS];
  logic [15:0] sp;
  logic [15:0] hl;
  logic        carry;
  logic        equal;
  logic        less;

  exec_result_t pending_results [$];
  int mismatch_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void reset_machine();
    foreach (gpr[i]) gpr[i] = '0;
    foreach (port_latch[i]) port_latch[i] = '0;
    data_mem.delete();
    written_addrs.delete();
    sp = SP_RESET;
    hl = '0;
    carry = 1'b0;
    equal = 1'b0;
    less = 1'b0;
  endfunction

  // remember which bytes hold data so loads never touch unwritten memory
  function automatic void write_mem(int addr, logic [7:0] value);
    if (!data_mem.exists(addr)) written_addrs.push_back(addr);
    data_mem[addr] = value;
  endfunction

  // execute one instruction on the machine state and return what it reports
  function automatic exec_result_t run_instruction(instr_word_t w);
    int r;
    int p;
    int a;
    logic [7:0] rv;
    logic [7:0] diff;
    exec_result_t res;
    r = w.reg_select % NUM_REGS;
    p = w.port_number % NUM_PORTS;
    a = w.mem_address % MEM_DEPTH;
    rv = gpr[r];
    res = '0;
    case (w.command)
      CMD_MW:   gpr[r] = w.immediate;
      CMD_LW:   gpr[r] = data_mem[a];
      CMD_SW:   write_mem(a, rv);
      CMD_PUSH: begin
        write_mem(sp % MEM_DEPTH, w.immediate);
        sp = sp - 16'd1;
      end
      CMD_POP: begin
        sp = sp + 16'd1;
        gpr[r] = data_mem[sp % MEM_DEPTH];
      end
      CMD_LDA:  hl = w.mem_address;
      CMD_JNZ: begin
        if (gpr[0] != 8'd0) begin
          res.jump_taken = 1'b1;
          res.jump_target = w.immediate;
        end
      end
      CMD_INB:  gpr[r] = port_latch[p];
      CMD_OUTB: port_latch[p] = rv;
      CMD_ADD:  gpr[r] = rv + w.immediate;
      CMD_ADC:  gpr[r] = rv + w.immediate + {7'd0, carry};
      CMD_AND:  gpr[r] = rv & w.immediate;
      CMD_OR:   gpr[r] = rv | w.immediate;
      CMD_NOR:  gpr[r] = ~(rv | w.immediate);
      CMD_CMP: begin
        diff = rv - w.immediate;
        carry = rv < w.immediate;
        equal = rv == w.immediate;
        less = diff > rv;
      end
      default: ;
    endcase
    res.reg_value = gpr[r];
    res.carry = carry;
    res.equal = equal;
    res.less = less;
    res.stack_ptr = sp;
    res.hl = hl;
    res.port_value = port_latch[p];
    return res;
  endfunction

  // offer one word, wait for it to be taken, then record its result
  task automatic send_word(input instr_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      instr_ch.valid <= 1'b0;
      @(posedge clk);
    end
    instr_ch.valid <= 1'b1;
    instr_ch.command <= w.command;
    instr_ch.reg_select <= w.reg_select;
    instr_ch.immediate <= w.immediate;
    instr_ch.mem_address <= w.mem_address;
    instr_ch.port_number <= w.port_number;
    @(posedge clk);
    while (!instr_ch.ready) @(posedge clk);
    pending_results.push_back(run_instruction(w));
  endtask

  task automatic send_op(input logic [3:0] cmd, input logic [2:0] r, input logic [7:0] imm,
                         input logic [15:0] addr, input logic [7:0] port);
    instr_word_t w;
    w.command = cmd;
    w.reg_select = r;
    w.immediate = imm;
    w.mem_address = addr;
    w.port_number = port;
    send_word(w);
  endtask

  // stop sending until every outstanding result is back
  task automatic drain_results();
    instr_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_result();
    exec_result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result word arrived with nothing expected", $time);
      mismatch_count++;
    end else begin
      want = pending_results.pop_front();
      check_field("reg_value", 16'(want.reg_value), 16'(result_ch.reg_value));
      check_field("carry_out", 16'(want.carry), 16'(result_ch.carry_out));
      check_field("equal_out", 16'(want.equal), 16'(result_ch.equal_out));
      check_field("less_out", 16'(want.less), 16'(result_ch.less_out));
      check_field("jump_taken", 16'(want.jump_taken), 16'(result_ch.jump_taken));
      check_field("jump_target", 16'(want.jump_target), 16'(result_ch.jump_target));
      check_field("stack_ptr_out", want.stack_ptr, result_ch.stack_ptr_out);
      check_field("hl_out", want.hl, result_ch.hl_out);
      check_field("port_value", 16'(want.port_value), 16'(result_ch.port_value));
    end
  endtask

  // result side: check what is taken, then pick next cycle's ready
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) check_result();
      result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // random instruction, steered so that loads and pops only read written bytes
  function automatic instr_word_t random_word();
    instr_word_t w;
    w.command = 4'($urandom_range(14));
    if ($urandom_range(99) < 3) w.command = CMD_UNDEF;
    w.reg_select = 3'($urandom);
    if ($urandom_range(9) == 0)
      w.immediate = $urandom_range(1) ? 8'hFF : 8'h00;
    else
      w.immediate = 8'($urandom);
    w.mem_address = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(63));
    w.port_number = ($urandom_range(1) == 0) ? 8'($urandom_range(7)) : 8'($urandom);
    if (w.command == CMD_LW) begin
      if (written_addrs.size() == 0)
        w.command = CMD_SW;
      else
        w.mem_address = 16'(written_addrs[$urandom_range(written_addrs.size() - 1)]);
    end
    if (w.command == CMD_POP && !data_mem.exists((int'(sp) + 1) % MEM_DEPTH))
      w.command = CMD_PUSH;
    return w;
  endfunction

  // arithmetic wrap, carry into adc, logic ops, compare outcomes, jumps, undefined code
  task automatic test_alu_and_flags();
    send_op(CMD_MW,   3'd0, 8'h00, 16'h0000, 8'h00);
    send_op(CMD_JNZ,  3'd0, 8'hAA, 16'h0000, 8'h00);
    send_op(CMD_MW,   3'd7, 8'hFF, 16'h0000, 8'h00);
    send_op(CMD_ADD,  3'd7, 8'h01, 16'h0000, 8'h00);
    send_op(CMD_MW,   3'd0, 8'h80, 16'h0000, 8'h00);
    send_op(CMD_JNZ,  3'd2, 8'hFF, 16'h0000, 8'h00);
    send_op(CMD_CMP,  3'd0, 8'h81, 16'h0000, 8'h00);
    send_op(CMD_ADC,  3'd0, 8'h7F, 16'h0000, 8'h00);
    send_op(CMD_CMP,  3'd0, 8'h00, 16'h0000, 8'h00);
    send_op(CMD_MW,   3'd3, 8'hF0, 16'h0000, 8'h00);
    send_op(CMD_AND,  3'd3, 8'h3C, 16'h0000, 8'h00);
    send_op(CMD_OR,   3'd3, 8'h0F, 16'h0000, 8'h00);
    send_op(CMD_NOR,  3'd3, 8'h00, 16'h0000, 8'h00);
    send_op(CMD_CMP,  3'd3, 8'h01, 16'h0000, 8'h00);
    send_op(CMD_UNDEF, 3'd3, 8'hFF, 16'hFFFF, 8'hFF);
  endtask

  // port latches at both ends of the range, hl load
  task automatic test_ports_and_hl();
    send_op(CMD_OUTB, 3'd3, 8'h00, 16'h0000, 8'hFF);
    send_op(CMD_INB,  3'd5, 8'h00, 16'h0000, 8'hFF);
    send_op(CMD_OUTB, 3'd7, 8'h00, 16'h0000, 8'h00);
    send_op(CMD_LDA,  3'd0, 8'h00, 16'hFFFF, 8'h00);
  endtask

  // store and load at both ends, stack wrap through address zero
  task automatic test_memory_and_stack();
    send_op(CMD_MW,   3'd1, 8'hA5, 16'h0000, 8'h00);
    send_op(CMD_SW,   3'd1, 8'h00, 16'h0000, 8'h00);
    send_op(CMD_POP,  3'd2, 8'h00, 16'h0000, 8'h00);
    send_op(CMD_PUSH, 3'd0, 8'h3C, 16'h0000, 8'h00);
    send_op(CMD_PUSH, 3'd0, 8'hFF, 16'h0000, 8'h00);
    send_op(CMD_POP,  3'd4, 8'h00, 16'h0000, 8'h00);
    send_op(CMD_LW,   3'd6, 8'h00, 16'h0000, 8'h00);
  endtask

  task automatic test_random(input int count, input int send_idle, input int recv_stall);
    idle_pct = send_idle;
    stall_pct = recv_stall;
    repeat (count) send_word(random_word());
    drain_results();
  endtask

  initial begin
    rst <= 1'b1;
    instr_ch.valid <= 1'b0;
    instr_ch.command <= '0;
    instr_ch.reg_select <= '0;
    instr_ch.immediate <= '0;
    instr_ch.mem_address <= '0;
    instr_ch.port_number <= '0;
    reset_machine();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_alu_and_flags();
    test_ports_and_hl();
    test_memory_and_stack();
    drain_results();

    test_random(150, 0, 0);
    test_random(150, 45, 0);
    test_random(150, 0, 45);
    test_random(150, 28, 28);

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hard stop if the handshake hangs
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
